/* rtl/core/swoa_pkg.sv */
`timescale 1ns / 1ps

package swoa_pkg;

   // Number of sonar sensors that take part; readings from higher indexes are ignored.
   localparam int NUM_SENSORS = 16;

   // Field and register widths.
   localparam int IndexWidth     = 4;
   localparam int ValueWidth     = 11;
   localparam int SpeedWidth     = 13;
   localparam int CfgSpeedWidth  = 12;
   localparam int ThresholdWidth = 16;
   localparam int SumWidth       = 22;
   localparam int IncWidth       = 21;
   localparam int WeightWidth    = 10;
   localparam int NearWidth      = 12;
   localparam int LimitWidth     = 28;
   localparam int CsrIndexWidth  = 2;
   localparam int CsrDataWidth   = 16;

   // Register reset values.
   localparam logic [ThresholdWidth-1:0] ThresholdReset = 16'd100;
   localparam logic [CfgSpeedWidth-1:0]  ForwardReset   = 12'd1341;
   localparam logic [CfgSpeedWidth-1:0]  TurnReset      = 12'd939;

   // Reading scale: a reading counts when 5*value is above this offset.
   localparam logic [ValueWidth-1:0] ValueMax   = 11'd1024;
   localparam logic [12:0]           NearOffset = 13'd2048;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_WEIGHT_THRESHOLD = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FORWARD_SPEED    = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_TURN_SPEED       = 2'd2;

   // Heading state.
   typedef enum logic [1:0] {
      MODE_FORWARD    = 2'd0,
      MODE_TURN_LEFT  = 2'd1,
      MODE_TURN_RIGHT = 2'd2
   } mode_type;

   // Left wheel weight of each sensor.
   function automatic logic [WeightWidth-1:0] left_weight(input logic [IndexWidth-1:0] idx);
      logic [WeightWidth-1:0] w;
      unique case (idx)
         4'd0:    w = 10'd150;
         4'd1:    w = 10'd200;
         4'd2:    w = 10'd300;
         4'd3:    w = 10'd600;
         default: w = '0;
      endcase
      return w;
   endfunction

   // Right wheel weight of each sensor.
   function automatic logic [WeightWidth-1:0] right_weight(input logic [IndexWidth-1:0] idx);
      logic [WeightWidth-1:0] w;
      unique case (idx)
         4'd4:    w = 10'd600;
         4'd5:    w = 10'd300;
         4'd6:    w = 10'd200;
         4'd7:    w = 10'd150;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/sonar_weighted_obstacle_avoider.sv */
`timescale 1ns / 1ps

// Sonar weighted obstacle avoider. The block takes one sonar reading per clock cycle and
// weights near readings into a left and a right wheel sum. A reading flagged as the last of
// a round steps the heading machine (forward, turning left, turning right) and yields one
// transfer of wheel speeds, after which both sums restart from zero. A reading passes two
// registers: the weighted increment is registered first, then the accumulator update and the
// heading decision load the result register. The single accumulator update per cycle sets the
// rate of one reading per cycle; the input only waits while a finished result is held and a
// further round end arrives.
module sonar_weighted_obstacle_avoider #(
   parameter int NUM_SENSORS = swoa_pkg::NUM_SENSORS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Reading channel.
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [swoa_pkg::IndexWidth-1:0]        req_sensor_index,
   input  logic [swoa_pkg::ValueWidth-1:0]        req_sensor_value,
   input  logic                                   req_round_last,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [swoa_pkg::SpeedWidth-1:0] rsp_left_speed,
   output logic signed [swoa_pkg::SpeedWidth-1:0] rsp_right_speed,
   output logic [1:0]                             rsp_heading_mode,
   // Configuration channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [swoa_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [swoa_pkg::CsrDataWidth-1:0]      csr_data
);

   // Configuration registers.
   logic [swoa_pkg::ThresholdWidth-1:0] threshold_ff;
   logic [swoa_pkg::CfgSpeedWidth-1:0]  forward_ff;
   logic [swoa_pkg::CfgSpeedWidth-1:0]  turn_ff;

   // Increment stage.
   logic                              p_valid_ff, p_valid_in;
   logic                              p_last_ff;
   logic [swoa_pkg::IncWidth-1:0]     p_left_inc_ff, p_left_inc_in;
   logic [swoa_pkg::IncWidth-1:0]     p_right_inc_ff, p_right_inc_in;
   logic                              p_adv;

   logic [swoa_pkg::ValueWidth-1:0]   v_clamp;
   logic [12:0]                       five_v;
   logic                              near;
   logic [swoa_pkg::NearWidth-1:0]    near_m;

   // Accumulator and heading state.
   logic [swoa_pkg::SumWidth-1:0]     left_sum_ff, left_sum_in;
   logic [swoa_pkg::SumWidth-1:0]     right_sum_ff, right_sum_in;
   logic [swoa_pkg::SumWidth:0]       left_total, right_total;
   logic [swoa_pkg::SumWidth-1:0]     left_sat, right_sat;
   logic [swoa_pkg::LimitWidth-1:0]   limit;
   logic                              left_hi, right_hi;
   swoa_pkg::mode_type                mode_ff, mode_in;

   // Result register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [swoa_pkg::SpeedWidth-1:0]   rsp_left_ff, rsp_left_in;
   logic [swoa_pkg::SpeedWidth-1:0]   rsp_right_ff, rsp_right_in;
   logic [1:0]                        rsp_mode_ff;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= swoa_pkg::ThresholdReset;
         forward_ff   <= swoa_pkg::ForwardReset;
         turn_ff      <= swoa_pkg::TurnReset;
      end else if (csr_valid) begin
         if (csr_index == swoa_pkg::CSR_WEIGHT_THRESHOLD) begin
            threshold_ff <= csr_data;
         end
         if (csr_index == swoa_pkg::CSR_FORWARD_SPEED) begin
            forward_ff <= csr_data[swoa_pkg::CfgSpeedWidth-1:0];
         end
         if (csr_index == swoa_pkg::CSR_TURN_SPEED) begin
            turn_ff <= csr_data[swoa_pkg::CfgSpeedWidth-1:0];
         end
      end
   end

   // Flow control: the increment stage holds only when it carries a round end and
   // the result register is still occupied.
   assign p_adv     = p_valid_ff && !(p_last_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready = !p_valid_ff || p_adv;

   // Weighted increment of the incoming reading.
   always_comb begin
      v_clamp = (req_sensor_value > swoa_pkg::ValueMax) ? swoa_pkg::ValueMax : req_sensor_value;
      five_v  = {v_clamp, 2'b00} + {2'b00, v_clamp};
      near    = (five_v > swoa_pkg::NearOffset) &&
                ({1'b0, req_sensor_index} < 5'(NUM_SENSORS));
      near_m  = near ? swoa_pkg::NearWidth'(five_v - swoa_pkg::NearOffset) : '0;
      p_left_inc_in  = swoa_pkg::IncWidth'(swoa_pkg::left_weight(req_sensor_index)) *
                       swoa_pkg::IncWidth'(near_m);
      p_right_inc_in = swoa_pkg::IncWidth'(swoa_pkg::right_weight(req_sensor_index)) *
                       swoa_pkg::IncWidth'(near_m);
      p_valid_in     = (req_valid && req_ready) || (p_valid_ff && !p_adv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         p_last_ff      <= req_round_last;
         p_left_inc_ff  <= p_left_inc_in;
         p_right_inc_ff <= p_right_inc_in;
      end
   end

   // Saturating accumulation and comparison with threshold*3072.
   always_comb begin
      left_total  = {1'b0, left_sum_ff} + (swoa_pkg::SumWidth + 1)'(p_left_inc_ff);
      right_total = {1'b0, right_sum_ff} + (swoa_pkg::SumWidth + 1)'(p_right_inc_ff);
      left_sat    = left_total[swoa_pkg::SumWidth] ? '1 : left_total[swoa_pkg::SumWidth-1:0];
      right_sat   = right_total[swoa_pkg::SumWidth] ? '1 : right_total[swoa_pkg::SumWidth-1:0];
      limit       = {2'b00, threshold_ff, 10'b0} + {1'b0, threshold_ff, 11'b0};
      left_hi     = swoa_pkg::LimitWidth'(left_sat) > limit;
      right_hi    = swoa_pkg::LimitWidth'(right_sat) > limit;
      left_sum_in  = left_sum_ff;
      right_sum_in = right_sum_ff;
      if (p_adv) begin
         left_sum_in  = p_last_ff ? '0 : left_sat;
         right_sum_in = p_last_ff ? '0 : right_sat;
      end
   end

   // Heading machine: next state.
   always_comb begin
      mode_in = mode_ff;
      if (p_adv && p_last_ff) begin
         unique case (mode_ff)
            swoa_pkg::MODE_TURN_LEFT,
            swoa_pkg::MODE_TURN_RIGHT: begin
               mode_in = (left_hi || right_hi) ? mode_ff : swoa_pkg::MODE_FORWARD;
            end
            default: begin
               priority if (left_hi) begin
                  mode_in = swoa_pkg::MODE_TURN_LEFT;
               end else if (right_hi) begin
                  mode_in = swoa_pkg::MODE_TURN_RIGHT;
               end else begin
                  mode_in = swoa_pkg::MODE_FORWARD;
               end
            end
         endcase
      end
   end

   // Heading machine: wheel speeds of the new state.
   always_comb begin
      unique case (mode_in)
         swoa_pkg::MODE_TURN_LEFT: begin
            rsp_left_in  = {1'b0, turn_ff};
            rsp_right_in = -{1'b0, turn_ff};
         end
         swoa_pkg::MODE_TURN_RIGHT: begin
            rsp_left_in  = -{1'b0, turn_ff};
            rsp_right_in = {1'b0, turn_ff};
         end
         default: begin
            rsp_left_in  = {1'b0, forward_ff};
            rsp_right_in = {1'b0, forward_ff};
         end
      endcase
      rsp_valid_in = (p_adv && p_last_ff) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_sum_ff  <= '0;
         right_sum_ff <= '0;
         mode_ff      <= swoa_pkg::MODE_FORWARD;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_sum_ff  <= left_sum_in;
         right_sum_ff <= right_sum_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads when a round end leaves the increment stage.
   always_ff @(posedge clock) begin
      if (p_adv && p_last_ff) begin
         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
         rsp_mode_ff  <= mode_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_speed   = rsp_left_ff;
   assign rsp_right_speed  = rsp_right_ff;
   assign rsp_heading_mode = rsp_mode_ff;

endmodule

/* rtl/core/swoa_checker.sv */
`timescale 1ns / 1ps

module swoa_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [swoa_pkg::SpeedWidth-1:0] rsp_left_speed,
   input logic signed [swoa_pkg::SpeedWidth-1:0] rsp_right_speed,
   input logic [1:0]                             rsp_heading_mode
);

   // A stalled result transfer keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_speed) &&
      $stable(rsp_right_speed) && $stable(rsp_heading_mode))
      else $error("result changed while stalled");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Going straight drives both wheels at the same speed.
   a_forward_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_heading_mode == swoa_pkg::MODE_FORWARD |->
      rsp_left_speed == rsp_right_speed)
      else $error("forward result with unequal wheel speeds");

   // A turn spins in place: the wheel speeds are opposite.
   a_turn_opposite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_heading_mode == swoa_pkg::MODE_TURN_LEFT ||
      rsp_heading_mode == swoa_pkg::MODE_TURN_RIGHT) |->
      swoa_pkg::SpeedWidth'(rsp_left_speed + rsp_right_speed) == '0)
      else $error("turn result with wheel speeds that are not opposite");

endmodule

bind sonar_weighted_obstacle_avoider swoa_checker u_swoa_checker (.*);

/* tb/sonar_weighted_obstacle_avoider_tb.sv */
`timescale 1ns / 1ps

module sonar_weighted_obstacle_avoider_tb;

   localparam int unsigned CYCLE_LIMIT   = 100000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned IDLE_PERCENT  = 17;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned VALUE_CLAMP   = 1024;
   localparam int unsigned NEAR_START    = 2048;
   localparam int unsigned LIMIT_SCALE   = 3072;
   localparam logic [swoa_pkg::SumWidth-1:0]      SUM_CEILING = '1;
   localparam logic [swoa_pkg::CsrIndexWidth-1:0] CSR_SPARE   = 2'd3;

   // One wheel command as the block should report it.
   typedef struct packed {
      logic [swoa_pkg::SpeedWidth-1:0] left_speed;
      logic [swoa_pkg::SpeedWidth-1:0] right_speed;
      swoa_pkg::mode_type              heading;
   } wheel_cmd_type;

   logic                                   clock            = 1'b0;
   logic                                   reset            = 1'b1;
   logic                                   req_valid        = 1'b0;
   logic                                   req_ready;
   logic [swoa_pkg::IndexWidth-1:0]        req_sensor_index = '0;
   logic [swoa_pkg::ValueWidth-1:0]        req_sensor_value = '0;
   logic                                   req_round_last   = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_ready        = 1'b0;
   logic signed [swoa_pkg::SpeedWidth-1:0] rsp_left_speed;
   logic signed [swoa_pkg::SpeedWidth-1:0] rsp_right_speed;
   logic [1:0]                             rsp_heading_mode;
   logic                                   csr_valid        = 1'b0;
   logic                                   csr_ready;
   logic [swoa_pkg::CsrIndexWidth-1:0]     csr_index        = '0;
   logic [swoa_pkg::CsrDataWidth-1:0]      csr_data         = '0;

   // Mirror of the block state and registers.
   logic [swoa_pkg::SumWidth-1:0]       left_total  = '0;
   logic [swoa_pkg::SumWidth-1:0]       right_total = '0;
   swoa_pkg::mode_type                  heading_q   = swoa_pkg::MODE_FORWARD;
   logic [swoa_pkg::ThresholdWidth-1:0] threshold_q = swoa_pkg::ThresholdReset;
   logic [swoa_pkg::CfgSpeedWidth-1:0]  forward_q   = swoa_pkg::ForwardReset;
   logic [swoa_pkg::CfgSpeedWidth-1:0]  turn_q      = swoa_pkg::TurnReset;

   wheel_cmd_type expected_commands[$];
   wheel_cmd_type oldest_cmd;
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;
   logic          idle_enable = 1'b1;

   sonar_weighted_obstacle_avoider u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sensor_index (req_sensor_index),
      .req_sensor_value (req_sensor_value),
      .req_round_last   (req_round_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_speed   (rsp_left_speed),
      .rsp_right_speed  (rsp_right_speed),
      .rsp_heading_mode (rsp_heading_mode),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // Run limit in case the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sonar_weighted_obstacle_avoider_tb: errors");
         $finish;
      end
   end

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // Fixed sensor weights: sensors 0..3 steer by the left sum, 4..7 by the right sum.
   function automatic int unsigned wheel_gain(input logic [swoa_pkg::IndexWidth-1:0] idx,
                                              input logic right_side);
      int unsigned gain;
      case (idx)
         4'd0:    gain = right_side ? 0 : 150;
         4'd1:    gain = right_side ? 0 : 200;
         4'd2:    gain = right_side ? 0 : 300;
         4'd3:    gain = right_side ? 0 : 600;
         4'd4:    gain = right_side ? 600 : 0;
         4'd5:    gain = right_side ? 300 : 0;
         4'd6:    gain = right_side ? 200 : 0;
         4'd7:    gain = right_side ? 150 : 0;
         default: gain = 0;
      endcase
      return gain;
   endfunction

   function automatic logic [swoa_pkg::SumWidth-1:0] add_saturating(
         input logic [swoa_pkg::SumWidth-1:0] acc, input int unsigned inc);
      longint unsigned total;
      total = 64'(acc) + 64'(inc);
      return (total > 64'(SUM_CEILING)) ? SUM_CEILING : total[swoa_pkg::SumWidth-1:0];
   endfunction

   // Accumulate one reading; at a round end, step the heading and queue the command.
   task automatic predict_wheel_command(input logic [swoa_pkg::IndexWidth-1:0] idx,
                                        input logic [swoa_pkg::ValueWidth-1:0] raw,
                                        input logic last);
      int unsigned                     value;
      int unsigned                     nearness;
      longint unsigned                 limit;
      logic                            left_high;
      logic                            right_high;
      logic [swoa_pkg::SpeedWidth-1:0] turn_pos;
      logic [swoa_pkg::SpeedWidth-1:0] turn_neg;
      wheel_cmd_type                   cmd;
      value = (32'(raw) > VALUE_CLAMP) ? VALUE_CLAMP : 32'(raw);
      if (5 * value > NEAR_START) begin
         nearness    = 5 * value - NEAR_START;
         left_total  = add_saturating(left_total, wheel_gain(idx, 1'b0) * nearness);
         right_total = add_saturating(right_total, wheel_gain(idx, 1'b1) * nearness);
      end
      if (last) begin
         limit      = 64'(threshold_q);
         limit      = limit * LIMIT_SCALE;
         left_high  = 64'(left_total) > limit;
         right_high = 64'(right_total) > limit;
         turn_pos   = {1'b0, turn_q};
         turn_neg   = -{1'b0, turn_q};
         cmd.left_speed  = {1'b0, forward_q};
         cmd.right_speed = {1'b0, forward_q};
         if (heading_q == swoa_pkg::MODE_TURN_LEFT || heading_q == swoa_pkg::MODE_TURN_RIGHT)
         begin
            // A turn holds while either side is still crowded.
            if (left_high || right_high) begin
               if (heading_q == swoa_pkg::MODE_TURN_LEFT) begin
                  cmd.left_speed  = turn_pos;
                  cmd.right_speed = turn_neg;
               end else begin
                  cmd.left_speed  = turn_neg;
                  cmd.right_speed = turn_pos;
               end
            end else begin
               heading_q = swoa_pkg::MODE_FORWARD;
            end
         end else begin
            heading_q = swoa_pkg::MODE_FORWARD;
            if (left_high) begin
               cmd.left_speed  = turn_pos;
               cmd.right_speed = turn_neg;
               heading_q       = swoa_pkg::MODE_TURN_LEFT;
            end else if (right_high) begin
               cmd.left_speed  = turn_neg;
               cmd.right_speed = turn_pos;
               heading_q       = swoa_pkg::MODE_TURN_RIGHT;
            end
         end
         cmd.heading = heading_q;
         expected_commands.push_back(cmd);
         left_total  = '0;
         right_total = '0;
      end
   endtask

   // Result side: random stalls and a check of every transfer against the oldest command.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_commands.size() == 0) begin
               flag_error($sformatf("unexpected result: left %0d right %0d mode %0d",
                                    rsp_left_speed, rsp_right_speed, rsp_heading_mode));
            end else begin
               oldest_cmd = expected_commands.pop_front();
               if (rsp_left_speed !== oldest_cmd.left_speed ||
                   rsp_right_speed !== oldest_cmd.right_speed ||
                   rsp_heading_mode !== oldest_cmd.heading) begin
                  flag_error($sformatf(
                     "result mismatch: expected left %0d right %0d mode %0d, got %0d %0d %0d",
                     $signed(oldest_cmd.left_speed), $signed(oldest_cmd.right_speed),
                     oldest_cmd.heading, rsp_left_speed, rsp_right_speed,
                     rsp_heading_mode));
               end
            end
         end
         rsp_ready <= !(idle_enable && ($urandom_range(99) < IDLE_PERCENT));
      end
   end

   // Send one reading, with optional idle cycles ahead of it.
   task automatic send_reading(input logic [swoa_pkg::IndexWidth-1:0] idx,
                               input logic [swoa_pkg::ValueWidth-1:0] value,
                               input logic last);
      while (idle_enable && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sensor_index <= idx;
      req_sensor_value <= value;
      req_round_last   <= last;
      do @(posedge clock); while (!req_ready);
      predict_wheel_command(idx, value, last);
   endtask

   // Hold the input until every command has come back and the pipeline is empty.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [swoa_pkg::CsrIndexWidth-1:0] index,
                                 input logic [swoa_pkg::CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (index)
         swoa_pkg::CSR_WEIGHT_THRESHOLD: threshold_q = data;
         swoa_pkg::CSR_FORWARD_SPEED:    forward_q   = data[swoa_pkg::CfgSpeedWidth-1:0];
         swoa_pkg::CSR_TURN_SPEED:       turn_q      = data[swoa_pkg::CfgSpeedWidth-1:0];
         default: ;
      endcase
   endtask

   // Random rounds of one to eight readings, with a few merged or split rounds.
   task automatic send_random_rounds(input int count);
      int                              remaining;
      int                              len;
      int                              k;
      int                              pick;
      logic                            last;
      logic [swoa_pkg::IndexWidth-1:0] idx;
      logic [swoa_pkg::ValueWidth-1:0] value;
      remaining = count;
      while (remaining > 0) begin
         len = $urandom_range(8, 1);
         if (len > remaining) len = remaining;
         for (k = 0; k < len; k++) begin
            idx  = ($urandom_range(99) < 85) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
            pick = $urandom_range(99);
            if (pick < 25) value = 11'($urandom_range(409));
            else if (pick < 85) value = 11'($urandom_range(1024, 410));
            else value = 11'($urandom_range(2047, 1025));
            if (k == len - 1) last = ($urandom_range(99) >= 5);
            else last = ($urandom_range(99) < 3);
            send_reading(idx, value, last);
         end
         remaining -= len;
      end
   endtask

   // Reset register values: value extremes, every sensor group, turn hold and release.
   task automatic test_reset_values();
      send_reading(4'd0, 11'd0, 1'b1);
      send_reading(4'd3, 11'd1024, 1'b1);
      send_reading(4'd4, 11'd1024, 1'b1);
      send_reading(4'd8, 11'd1024, 1'b1);
      send_reading(4'd5, 11'd2047, 1'b1);
      send_reading(4'd15, 11'd1500, 1'b1);
      send_reading(4'd0, 11'd409, 1'b0);
      send_reading(4'd1, 11'd410, 1'b0);
      send_reading(4'd2, 11'd500, 1'b0);
      send_reading(4'd7, 11'd1025, 1'b1);
   endtask

   // Both sums driven into saturation, then a threshold too large to be crossed and zero.
   task automatic test_saturation_and_limits();
      repeat (3) send_reading(4'd3, 11'd1024, 1'b0);
      repeat (3) send_reading(4'd4, 11'd1024, 1'b0);
      send_reading(4'd9, 11'd2047, 1'b1);
      send_reading(4'd0, 11'd0, 1'b1);
      wait_for_drain();
      write_register(swoa_pkg::CSR_WEIGHT_THRESHOLD, 16'hFFFF);
      repeat (2) send_reading(4'd3, 11'd1024, 1'b0);
      send_reading(4'd3, 11'd1024, 1'b1);
      wait_for_drain();
      write_register(swoa_pkg::CSR_WEIGHT_THRESHOLD, 16'd0);
      send_reading(4'd0, 11'd0, 1'b1);
      send_reading(4'd0, 11'd410, 1'b1);
      send_reading(4'd0, 11'd0, 1'b1);
   endtask

   // Speed registers at their extremes, with bits above the register width set.
   task automatic test_speed_extremes();
      wait_for_drain();
      write_register(swoa_pkg::CSR_FORWARD_SPEED, 16'h0000);
      write_register(swoa_pkg::CSR_TURN_SPEED, 16'hFFFF);
      write_register(CSR_SPARE, 16'hFFFF);
      send_reading(4'd3, 11'd1024, 1'b1);
      send_reading(4'd0, 11'd0, 1'b1);
      wait_for_drain();
      write_register(swoa_pkg::CSR_FORWARD_SPEED, 16'hFFFF);
      write_register(swoa_pkg::CSR_TURN_SPEED, 16'hF000);
      send_reading(4'd6, 11'd1024, 1'b1);
      send_reading(4'd0, 11'd0, 1'b1);
   endtask

   // Phases of random rounds, each under its own register setting.
   task automatic test_random_rounds();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         wait_for_drain();
         case (phase)
            0:       write_register(swoa_pkg::CSR_WEIGHT_THRESHOLD, 16'd0);
            1:       write_register(swoa_pkg::CSR_WEIGHT_THRESHOLD, 16'hFFFF);
            default: write_register(swoa_pkg::CSR_WEIGHT_THRESHOLD,
                                    16'($urandom_range(1400, 20)));
         endcase
         case (phase)
            2: begin
               write_register(swoa_pkg::CSR_FORWARD_SPEED, 16'h0000);
               write_register(swoa_pkg::CSR_TURN_SPEED, 16'h0000);
            end
            3: begin
               write_register(swoa_pkg::CSR_FORWARD_SPEED, 16'hFFFF);
               write_register(swoa_pkg::CSR_TURN_SPEED, 16'hFFFF);
            end
            default: begin
               write_register(swoa_pkg::CSR_FORWARD_SPEED, 16'($urandom_range(65535)));
               write_register(swoa_pkg::CSR_TURN_SPEED, 16'($urandom_range(65535)));
            end
         endcase
         if (phase == 6) write_register(CSR_SPARE, 16'($urandom_range(65535)));
         // Phase four runs with no idling on either side.
         idle_enable = (phase != 4);
         send_random_rounds(103);
         if (phase == 5) begin
            wait_for_drain();
            send_random_rounds(20);
         end
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_saturation_and_limits();
      test_speed_extremes();
      test_random_rounds();
      wait_for_drain();
      if (expected_commands.size() != 0) begin
         flag_error($sformatf("%0d results never arrived", expected_commands.size()));
      end
      if (error_count == 0) begin
         $display("sonar_weighted_obstacle_avoider_tb: clean");
      end else begin
         $display("sonar_weighted_obstacle_avoider_tb: errors");
      end
      $finish;
   end

endmodule
